>>> hw/rtl/vrbs_pkg.sv
// Shared types and constants for the variable-length record byte stack.
package vrbs_pkg;

   localparam int CAP_W      = 13;
   localparam int STATUS_W   = 3;
   localparam int BYTE_W     = 8;
   localparam int RCOUNT_W   = 6;
   localparam int REQ_W      = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - BYTE_W - RCOUNT_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

   typedef enum logic [REQ_W-1:0] {
      REQ_OPEN   = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_POP    = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_DATA_FULL  = 3'd2,
      ST_SLOTS_FULL = 3'd3,
      ST_TOO_LONG   = 3'd4,
      ST_NO_RECORD  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_STREAM,
      S_REFILL
   } ctl_state_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic                last;
      logic [RCOUNT_W-1:0] record_count;
   } result_type;

endpackage

>>> hw/rtl/vrbs_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module vrbs_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/vrbs_out_queue.sv
// Two-entry result queue that separates the result port from the control logic.
module vrbs_out_queue
   import vrbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       out_ready,
   output logic       out_valid,
   output result_type out_data,
   output logic [1:0] level
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;
   logic       pop;

   assign out_valid = (level_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (pop && !push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/variable_record_byte_stack_top.sv
// Top level of the variable-length record byte stack: control, stores and result path.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------------------
//  req_     | in        | req_tvalid/tready    | tuser request kind, tdata byte to append
//  rsp_     | out       | rsp_tvalid/tready    | tdata status/byte/count, tuser, tlast
//  csr_     | in        | csr_wr_en            | csr_wr_data: usable data capacity
//
// Open and append issue their result when accepted. A pop is accepted and then reads the
// record byte by byte through the single read port of the byte store; popping an empty
// record instead passes through a refill state, spent reloading the new top entry from
// the slot table. Each result passes the read stage and then the queue to reach the port.
// Reset clears the counters only; the stores need no clearing pass.
// A stalled result port stops new items and byte reads once queue and read stage hold two.
module variable_record_byte_stack_top
   import vrbs_pkg::*;
#(
   parameter int DATA_BYTES = 4096,
   parameter int MAX_DEPTH  = 32,
   parameter int RECORD_MAX = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic [REQ_W-1:0]      req_tuser,   // [1:0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] status, [10:3] out_byte,
                                              // [16:11] record_count, [23:17] zero
   output logic                  rsp_tuser,   // [0] byte_valid
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data
);

   localparam int AW   = $clog2(DATA_BYTES);
   localparam int UW   = $clog2(DATA_BYTES + 1);
   localparam int SW   = $clog2(MAX_DEPTH);
   localparam int CW   = $clog2(MAX_DEPTH + 1);
   localparam int LW   = $clog2(RECORD_MAX + 1);
   localparam int TW   = AW + LW;
   localparam int CMPW = (UW > CAP_W) ? UW : CAP_W;

   localparam logic [CMPW-1:0] DATA_LIMIT = CMPW'(DATA_BYTES);
   localparam logic [CW-1:0]   DEPTH_MAX  = CW'(MAX_DEPTH);
   localparam logic [LW-1:0]   LEN_MAX    = LW'(RECORD_MAX);

   ctl_state_type state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [AW-1:0]    top_off_ff, top_off_in;
   logic [LW-1:0]    top_len_ff, top_len_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    remain_ff, remain_in;
   logic             load_top_ff, load_top_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_mem_ff, s1_mem_in;
   result_type       s1_res_ff, s1_res_in;

   logic             byte_we, byte_re;
   logic [AW-1:0]    byte_waddr, byte_raddr;
   logic [BYTE_W-1:0] byte_wdata, byte_rdata;
   logic             tbl_we, tbl_re;
   logic [SW-1:0]    tbl_waddr, tbl_raddr;
   logic [TW-1:0]    tbl_wdata, tbl_rdata;

   logic [SW-1:0]    top_idx, next_idx;
   logic [CMPW-1:0]  cap_ext, used_ext, limit;
   logic [2:0]       occ;
   logic             slot_free, req_fire, q_pop;
   logic [1:0]       q_level;
   result_type       q_push_data, q_out;

   assign top_idx  = SW'(count_ff - CW'(1));
   assign next_idx = SW'(count_ff - CW'(2));
   assign cap_ext  = CMPW'(cap_ff);
   assign used_ext = CMPW'(used_ff);
   assign limit    = (cap_ext < DATA_LIMIT) ? cap_ext : DATA_LIMIT;

   // Space is counted for the item in the read stage and for one leaving the queue now.
   assign q_pop      = rsp_tvalid & rsp_tready;
   assign occ        = 3'(q_level) + 3'(s1_valid_ff) - 3'(q_pop);
   assign slot_free  = (occ < 3'd2);
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign req_fire   = req_tvalid & req_tready;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      top_off_in  = top_off_ff;
      top_len_in  = top_len_ff;
      rd_ptr_in   = rd_ptr_ff;
      remain_in   = remain_ff;
      load_top_in = 1'b0;
      s1_valid_in = 1'b0;
      s1_mem_in   = 1'b0;
      s1_res_in   = '{status: ST_OK, out_byte: '0, byte_valid: 1'b0, last: 1'b1,
                      record_count: '0};
      byte_we     = 1'b0;
      byte_waddr  = used_ff[AW-1:0];
      byte_wdata  = req_tdata;
      byte_re     = 1'b0;
      byte_raddr  = rd_ptr_ff;
      tbl_we      = 1'b0;
      tbl_waddr   = top_idx;
      tbl_wdata   = {top_off_ff, top_len_ff + LW'(1)};
      tbl_re      = 1'b0;
      tbl_raddr   = next_idx;

      // The new top entry read during a pop arrives in the next cycle.
      if (load_top_ff) begin
         top_off_in = tbl_rdata[TW-1:LW];
         top_len_in = tbl_rdata[LW-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  REQ_OPEN: begin
                     s1_valid_in = 1'b1;
                     if (count_ff == DEPTH_MAX) begin
                        s1_res_in.status = ST_SLOTS_FULL;
                     end else begin
                        tbl_we     = 1'b1;
                        tbl_waddr  = count_ff[SW-1:0];
                        tbl_wdata  = {used_ff[AW-1:0], LW'(0)};
                        top_off_in = used_ff[AW-1:0];
                        top_len_in = '0;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  REQ_APPEND: begin
                     s1_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        s1_res_in.status = ST_NO_RECORD;
                     end else if (used_ext >= limit) begin
                        s1_res_in.status = ST_DATA_FULL;
                     end else if (top_len_ff >= LEN_MAX) begin
                        s1_res_in.status = ST_TOO_LONG;
                     end else begin
                        byte_we    = 1'b1;
                        tbl_we     = 1'b1;
                        top_len_in = top_len_ff + LW'(1);
                        used_in    = used_ff + UW'(1);
                     end
                  end
                  REQ_POP: begin
                     if (count_ff == '0) begin
                        s1_valid_in      = 1'b1;
                        s1_res_in.status = ST_EMPTY;
                     end else begin
                        count_in    = count_ff - CW'(1);
                        used_in     = used_ff - UW'(top_len_ff);
                        tbl_re      = 1'b1;
                        load_top_in = 1'b1;
                        if (top_len_ff == '0) begin
                           s1_valid_in = 1'b1;
                           state_in    = S_REFILL;
                        end else begin
                           rd_ptr_in = top_off_ff;
                           remain_in = top_len_ff;
                           state_in  = S_STREAM;
                        end
                     end
                  end
                  default: begin
                     // Unused request kind: taken and dropped without a result.
                  end
               endcase
            end
         end
         S_STREAM: begin
            if (slot_free) begin
               byte_re              = 1'b1;
               s1_valid_in          = 1'b1;
               s1_mem_in            = 1'b1;
               s1_res_in.byte_valid = 1'b1;
               s1_res_in.last       = (remain_ff == LW'(1));
               rd_ptr_in            = rd_ptr_ff + AW'(1);
               remain_in            = remain_ff - LW'(1);
               if (remain_ff == LW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_REFILL: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      s1_res_in.record_count = RCOUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         used_ff     <= '0;
         cap_ff      <= CAP_RESET;
         load_top_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         used_ff     <= used_in;
         cap_ff      <= cap_in;
         load_top_ff <= load_top_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_off_ff <= top_off_in;
      top_len_ff <= top_len_in;
      rd_ptr_ff  <= rd_ptr_in;
      remain_ff  <= remain_in;
      s1_mem_ff  <= s1_mem_in;
      s1_res_ff  <= s1_res_in;
   end

   vrbs_ram #(
      .DEPTH(DATA_BYTES),
      .AW   (AW),
      .DW   (BYTE_W)
   ) u_byte_store (
      .clock  (clock),
      .wr_en  (byte_we),
      .wr_addr(byte_waddr),
      .wr_data(byte_wdata),
      .rd_en  (byte_re),
      .rd_addr(byte_raddr),
      .rd_data(byte_rdata)
   );

   vrbs_ram #(
      .DEPTH(MAX_DEPTH),
      .AW   (SW),
      .DW   (TW)
   ) u_slot_table (
      .clock  (clock),
      .wr_en  (tbl_we),
      .wr_addr(tbl_waddr),
      .wr_data(tbl_wdata),
      .rd_en  (tbl_re),
      .rd_addr(tbl_raddr),
      .rd_data(tbl_rdata)
   );

   always_comb begin
      q_push_data          = s1_res_ff;
      q_push_data.out_byte = s1_mem_ff ? byte_rdata : '0;
   end

   vrbs_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_valid_ff),
      .push_data(q_push_data),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .out_data (q_out),
      .level    (q_level)
   );

   assign rsp_tdata = {RSP_PAD_W'(0), q_out.record_count, q_out.out_byte, q_out.status};
   assign rsp_tuser = q_out.byte_valid;
   assign rsp_tlast = q_out.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_MAX)
      else $error("record count above slot table depth");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(DATA_BYTES))
      else $error("used bytes above data store size");

   a_stream_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (remain_ff != '0))
      else $error("streaming with no bytes left");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_level != 2'd2) || q_pop)
      else $error("result queue overflow");

   a_pop_reload: assert property (@(posedge clock) disable iff (reset)
      load_top_ff |-> (state_ff == S_STREAM) || (state_ff == S_REFILL))
      else $error("top entry reload outside a pop");

endmodule
